[design/biq_pkg.sv]
// Shared types, widths and register indexes for the biquad filter.
`default_nettype none
package biq_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int COEF_FRAC = 28;
   localparam int STATE_W   = SAMPLE_W + 8;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int RND_W     = PROD_W - COEF_FRAC;
   localparam int ACC_W     = ((RND_W > STATE_W) ? RND_W : STATE_W) + 2;
   localparam int NUM_COEFS = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_A0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_A1 = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_A2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_B1 = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_B2 = CSR_IDX_W'(4);

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic                       command;
      logic signed [SAMPLE_W-1:0] sample_in;
   } biq_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } biq_rsp_type;

   typedef enum logic [2:0] {
      ACC_NONE     = 3'd0,
      ACC_Y        = 3'd1,
      ACC_Z1_START = 3'd2,
      ACC_Z2_START = 3'd3,
      ACC_Z1_SUB   = 3'd4
   } biq_acc_op_type;

   typedef struct packed {
      logic                 load;
      logic                 clear;
      logic                 mul_en;
      logic                 op_sel_y;
      logic [CSR_IDX_W-1:0] coef_sel;
      logic                 rnd_en;
      biq_acc_op_type       acc_op;
      logic                 commit;
   } biq_cmd_type;

endpackage
`default_nettype wire

[design/biq_datapath.sv]
// Biquad datapath: coefficient registers, shared multiplier, rounding, accumulators, state.
`default_nettype none
module biq_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire biq_pkg::biq_cmd_type                  cmd,
   input  wire logic signed [biq_pkg::SAMPLE_W-1:0]   sample_in,
   input  wire logic                                  csr_wr_en,
   input  wire logic [biq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [biq_pkg::COEF_W-1:0]            csr_wdata,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_valid,
   output biq_pkg::biq_rsp_type                       rsp_payload,
   output logic                                       out_free
);
   import biq_pkg::*;

   function automatic logic over_sample(input logic signed [ACC_W-1:0] v);
      return !((&v[ACC_W-1:SAMPLE_W-1]) || !(|v[ACC_W-1:SAMPLE_W-1]));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
      if (over_sample(v)) begin
         return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic over_state(input logic signed [ACC_W-1:0] v);
      return !((&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1]));
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      if (over_state(v)) begin
         return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
      end
      return v[STATE_W-1:0];
   endfunction

   logic signed [COEF_W-1:0]   coef_ff [NUM_COEFS];
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [RND_W-1:0]    rnd_ff, rnd_in;
   logic signed [PROD_W-1:0]   rnd_sum;
   logic signed [ACC_W-1:0]    acc1_ff, acc2_ff;
   logic signed [STATE_W-1:0]  z1_ff, z2_ff;
   logic                       clip_ff;
   logic signed [ACC_W-1:0]    rnd_ext, y_sum, z2_sum;
   logic signed [SAMPLE_W-1:0] mul_op;
   logic                       rsp_valid_ff;
   biq_rsp_type                rsp_ff, rsp_in;

   // round half away from zero: negative products take one off the half bias
   assign rnd_sum = prod_ff + (PROD_W'(1) <<< (COEF_FRAC - 1)) - PROD_W'(prod_ff[PROD_W-1]);
   assign rnd_in  = rnd_sum[PROD_W-1:COEF_FRAC];
   assign rnd_ext = ACC_W'(rnd_ff);
   assign y_sum   = rnd_ext + ACC_W'(z1_ff);
   assign y_in    = sat_sample(y_sum);
   assign z2_sum  = acc2_ff - rnd_ext;
   assign mul_op  = cmd.op_sel_y ? y_ff : x_ff;

   always_comb begin
      rsp_in.sample_out = y_ff;
      rsp_in.clipped    = clip_ff | over_state(acc1_ff) | over_state(z2_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_A0] <= COEF_W'(1) <<< COEF_FRAC;
         coef_ff[REG_A1] <= '0;
         coef_ff[REG_A2] <= '0;
         coef_ff[REG_B1] <= '0;
         coef_ff[REG_B2] <= '0;
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_COEFS))) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= sample_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_op * coef_ff[cmd.coef_sel];
      end
      if (cmd.rnd_en) begin
         rnd_ff <= rnd_in;
      end
      case (cmd.acc_op)
         ACC_Y: begin
            y_ff    <= y_in;
            clip_ff <= over_sample(y_sum);
         end
         ACC_Z1_START: acc1_ff <= rnd_ext + ACC_W'(z2_ff);
         ACC_Z2_START: acc2_ff <= rnd_ext;
         ACC_Z1_SUB:   acc1_ff <= acc1_ff - rnd_ext;
         default: ;
      endcase
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         z1_ff <= '0;
         z2_ff <= '0;
      end else if (cmd.commit) begin
         z1_ff <= sat_state(acc1_ff);
         z2_ff <= sat_state(z2_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

[design/biq_ctrl.sv]
// Biquad controller: sequences the shared multiplier and accumulators per request.
`default_nettype none
module biq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_command,
   input  wire logic                  out_free,
   output logic                       req_stall,
   output biq_pkg::biq_cmd_type       cmd
);
   import biq_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_C0   = 8'b0000_0010,
      ST_C1   = 8'b0000_0100,
      ST_C2   = 8'b0000_1000,
      ST_C3   = 8'b0001_0000,
      ST_C4   = 8'b0010_0000,
      ST_C5   = 8'b0100_0000,
      ST_C6   = 8'b1000_0000
   } biq_state_type;

   biq_state_type state_ff, state_in;
   logic          accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.acc_op   = ACC_NONE;
      cmd.coef_sel = REG_A0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_C0;
               end
            end
         end
         ST_C0: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_C1;
         end
         ST_C1: begin
            cmd.rnd_en   = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = REG_A1;
            state_in     = ST_C2;
         end
         ST_C2: begin
            cmd.acc_op   = ACC_Y;
            cmd.rnd_en   = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = REG_A2;
            state_in     = ST_C3;
         end
         ST_C3: begin
            cmd.acc_op   = ACC_Z1_START;
            cmd.rnd_en   = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.op_sel_y = 1'b1;
            cmd.coef_sel = REG_B1;
            state_in     = ST_C4;
         end
         ST_C4: begin
            cmd.acc_op   = ACC_Z2_START;
            cmd.rnd_en   = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.op_sel_y = 1'b1;
            cmd.coef_sel = REG_B2;
            state_in     = ST_C5;
         end
         ST_C5: begin
            cmd.acc_op = ACC_Z1_SUB;
            cmd.rnd_en = 1'b1;
            state_in   = ST_C6;
         end
         ST_C6: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[design/biquad_tdf2_filter.sv]
// Top level of the transposed direct form II biquad filter.
// A filter request runs the controller through states C0 to C6, taking no new request;
// its response follows the commit in C6, which waits while the output is stalled. The
// single shared multiplier forms five products, each rounded in the following cycle.
// A clear request gives no response and leaves the controller idle.
// Synchronous reset zeroes the delay state, restores the coefficients, drops rsp_valid.
`default_nettype none
module biquad_tdf2_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire biq_pkg::biq_req_type              req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output biq_pkg::biq_rsp_type                   rsp_payload,
   input  wire logic                              csr_wr_en,
   input  wire logic [biq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [biq_pkg::COEF_W-1:0]        csr_wdata
);
   import biq_pkg::*;

   biq_cmd_type cmd;
   logic        out_free;

   biq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .out_free    (out_free),
      .req_stall   (req_stall),
      .cmd         (cmd)
   );

   biq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample_in   (req_payload.sample_in),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .out_free    (out_free)
   );

`ifndef NO_ASSERTIONS
   a_clear_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.command == CMD_CLEAR) |=> !req_stall)
      else $error("clear request left the controller busy");

   a_filter_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_payload.command == CMD_FILTER) |=> req_stall)
      else $error("filter request did not start the sequence");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not present a response");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a request in progress");
`endif

endmodule
`default_nettype wire
